// ===== hdl/bpk_pkg.sv =====
package bpk_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CUR_W        = $clog2(BUFFER_BYTES + 1);
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 6;
    localparam int BIT_W        = 4;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_REWIND = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(VALUE_W);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sweep;
        logic step;
        logic modify;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rem_zero;
        logic sweep_last;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== hdl/bpk_in_if.sv =====
interface bpk_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [bpk_pkg::VALUE_W-1:0] value;
    logic [bpk_pkg::COUNT_W-1:0] num_bits;

    modport source (output valid, output mode, output value, output num_bits, input ready);
    modport sink   (input valid, input mode, input value, input num_bits, output ready);
endinterface

// ===== hdl/bpk_out_if.sv =====
interface bpk_out_if;
    logic                        valid;
    logic                        ready;
    logic [bpk_pkg::VALUE_W-1:0] read_value;
    logic [bpk_pkg::CUR_W-1:0]   length_bytes;
    logic [bpk_pkg::CUR_W-1:0]   byte_cursor;
    logic [bpk_pkg::BIT_W-1:0]   bit_cursor;
    logic                        overflow;

    modport source (output valid, output read_value, output length_bytes,
                    output byte_cursor, output bit_cursor, output overflow, input ready);
    modport sink   (input valid, input read_value, input length_bytes,
                    input byte_cursor, input bit_cursor, input overflow, output ready);
endinterface

// ===== hdl/bpk_ctrl.sv =====
module bpk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    output bpk_pkg::dp_cmd_t  ctl,
    input  bpk_pkg::dp_sts_t  sts
);

    localparam logic [2:0] ST_SWEEP  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       clr_pend_reg;
    logic       clr_pend_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctl           = '0;
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    // the sweep after reset returns no beat; one after clear does
                    state_next    = clr_pend_reg ? ST_DONE : ST_IDLE;
                    clr_pend_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    case (in_mode)
                        bpk_pkg::MODE_CLEAR:
                        begin
                            state_next    = ST_SWEEP;
                            clr_pend_next = 1'b1;
                        end
                        bpk_pkg::MODE_REWIND: state_next = ST_DONE;
                        default:              state_next = ST_STEP;
                    endcase
                end
            end
            ST_STEP:
            begin
                if (sts.rem_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                ctl.modify = 1'b1;
                state_next = ST_STEP;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

// ===== hdl/bpk_datapath.sv =====
module bpk_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpk_pkg::dp_cmd_t              ctl,
    output bpk_pkg::dp_sts_t              sts,
    input  logic [1:0]                    in_mode,
    input  logic [bpk_pkg::VALUE_W-1:0]   in_value,
    input  logic [bpk_pkg::COUNT_W-1:0]   in_num_bits,
    bpk_out_if.source                     rsp
);

    localparam int ADDR_W  = bpk_pkg::ADDR_W;
    localparam int CUR_W   = bpk_pkg::CUR_W;
    localparam int VALUE_W = bpk_pkg::VALUE_W;
    localparam int COUNT_W = bpk_pkg::COUNT_W;
    localparam int BIT_W   = bpk_pkg::BIT_W;
    localparam logic [CUR_W-1:0] BUF_END = CUR_W'(bpk_pkg::BUFFER_BYTES);

    logic [7:0]         mem [bpk_pkg::BUFFER_BYTES];
    logic [7:0]         rd_data_reg;

    logic [CUR_W-1:0]   used_reg;
    logic [CUR_W-1:0]   byte_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               ovf_reg;
    logic               is_write_reg;
    logic               in_range_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] pos_reg;
    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] res_reg;
    logic [ADDR_W-1:0]  sweep_addr_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [CUR_W-1:0]   out_len_reg;
    logic [CUR_W-1:0]   out_byte_reg;
    logic [BIT_W-1:0]   out_bit_reg;
    logic               out_ovf_reg;

    logic [COUNT_W-1:0] sat_bits;
    logic               adv;
    logic [CUR_W-1:0]   adv_byte;
    logic               adv_in;
    logic [BIT_W-1:0]   avail;
    logic [BIT_W-1:0]   n;
    logic [7:0]         mask;
    logic [7:0]         wr_byte;
    logic [7:0]         rd_bits;

    assign sat_bits = (in_num_bits > bpk_pkg::MAX_BITS) ? bpk_pkg::MAX_BITS : in_num_bits;

    // a bit index of 8 means the byte is used up: move on before the next bit
    assign adv      = (bit_reg == BIT_W'(8));
    assign adv_byte = (adv && (byte_reg < BUF_END)) ? byte_reg + CUR_W'(1) : byte_reg;
    assign adv_in   = (adv_byte < BUF_END);

    // bits handled in this byte: what is left, up to the end of the byte
    assign avail   = BIT_W'(8) - bit_reg;
    assign n       = ({2'b00, avail} > rem_reg) ? rem_reg[BIT_W-1:0] : avail;
    assign mask    = ~(8'hFF << n);
    assign wr_byte = rd_data_reg | ((data_reg[7:0] & mask) << bit_reg[2:0]);
    assign rd_bits = in_range_reg ? ((rd_data_reg >> bit_reg[2:0]) & mask) : 8'h00;

    assign sts.rem_zero   = (rem_reg == '0);
    assign sts.sweep_last = (sweep_addr_reg == ADDR_W'(bpk_pkg::BUFFER_BYTES - 1));
    assign sts.out_busy   = out_valid_reg && !rsp.ready;

    always_ff @(posedge clk)
    begin
        if (ctl.sweep)
        begin
            mem[sweep_addr_reg] <= 8'h00;
        end
        else if (ctl.modify && in_range_reg && is_write_reg)
        begin
            mem[byte_reg[ADDR_W-1:0]] <= wr_byte;
        end
        if (ctl.step)
        begin
            rd_data_reg <= mem[adv_byte[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            byte_reg       <= '0;
            bit_reg        <= '0;
            ovf_reg        <= 1'b0;
            is_write_reg   <= 1'b0;
            in_range_reg   <= 1'b0;
            rem_reg        <= '0;
            pos_reg        <= '0;
            data_reg       <= '0;
            res_reg        <= '0;
            sweep_addr_reg <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                data_reg     <= in_value;
                rem_reg      <= sat_bits;
                pos_reg      <= '0;
                res_reg      <= '0;
                is_write_reg <= (in_mode == bpk_pkg::MODE_WRITE);
                case (in_mode)
                    bpk_pkg::MODE_CLEAR:
                    begin
                        used_reg       <= '0;
                        byte_reg       <= '0;
                        bit_reg        <= '0;
                        ovf_reg        <= 1'b0;
                        sweep_addr_reg <= '0;
                    end
                    bpk_pkg::MODE_REWIND:
                    begin
                        byte_reg <= '0;
                        bit_reg  <= '0;
                    end
                    bpk_pkg::MODE_WRITE:
                    begin
                        // first write to an empty buffer claims byte 0
                        if (used_reg == '0)
                        begin
                            used_reg <= CUR_W'(1);
                            byte_reg <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (ctl.step)
            begin
                byte_reg     <= adv_byte;
                in_range_reg <= adv_in;
                if (adv)
                begin
                    bit_reg <= '0;
                    if (is_write_reg && (used_reg < BUF_END))
                    begin
                        used_reg <= used_reg + CUR_W'(1);
                    end
                end
                if (!adv_in)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (ctl.modify)
            begin
                bit_reg  <= bit_reg + n;
                rem_reg  <= rem_reg - {2'b00, n};
                pos_reg  <= pos_reg + {2'b00, n};
                data_reg <= data_reg >> n;
                if (!is_write_reg)
                begin
                    res_reg <= res_reg | ({24'h000000, rd_bits} << pos_reg[4:0]);
                end
            end
            if (ctl.sweep)
            begin
                sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            out_value_reg <= res_reg;
            out_len_reg   <= used_reg;
            out_byte_reg  <= byte_reg;
            out_bit_reg   <= bit_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_value   = out_value_reg;
    assign rsp.length_bytes = out_len_reg;
    assign rsp.byte_cursor  = out_byte_reg;
    assign rsp.bit_cursor   = out_bit_reg;
    assign rsp.overflow     = out_ovf_reg;

`ifndef SYNTH
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_W'(8))
        else $error("bit cursor beyond 8");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_reg <= BUF_END) && (used_reg <= BUF_END))
        else $error("byte cursor or length beyond buffer end");

    a_modify_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.modify |-> (bit_reg < BIT_W'(8)) && (rem_reg != '0))
        else $error("byte update with exhausted byte or no bits left");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(ctl.load && (in_mode == bpk_pkg::MODE_CLEAR)) |=> ovf_reg)
        else $error("overflow flag dropped without clear");

    a_no_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !sts.out_busy)
        else $error("result loaded over an untaken beat");
`endif

endmodule

// ===== hdl/lsb_first_bit_packer_unit.sv =====
// LSB-first bit packer: a 1024-byte buffer with one shared byte/bit cursor. Each command beat
// gives exactly one result beat. After reset, and after every clear, the buffer is zeroed by a
// sweep of one byte per cycle, during which no command is taken. A write or read walks the bytes
// the access touches (at most five for 32 bits): for each byte a step state does the registered
// buffer read and a modify state the merge and, on a write, the write-back through the single
// buffer port; a last step state finds no bits left. Rewind resets the cursor and goes straight
// to the result. One command is processed at a time; the result register lets the next command
// be accepted while a result beat still waits to be taken.
module lsb_first_bit_packer_unit (
    input  logic      clk,
    input  logic      rst_n,
    bpk_in_if.sink    cmd,
    bpk_out_if.source rsp
);

    bpk_pkg::dp_cmd_t ctl;
    bpk_pkg::dp_sts_t sts;

    bpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_mode  (cmd.mode),
        .in_ready (cmd.ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    bpk_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_mode     (cmd.mode),
        .in_value    (cmd.value),
        .in_num_bits (cmd.num_bits),
        .rsp         (rsp)
    );

endmodule
